// ----- design/indexed_min_heap_queue_unit_assert.svh -----
// Assertion macros for the indexed min-heap queue unit.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Clocked check, masked while reset is high.
`define IMHQ_ASSERT(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Clocked check that also holds during reset.
`define IMHQ_ASSERT_ALWAYS(name, clk_s, prop, msg) \
  name: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ----- design/imhq_pkg.sv -----
// ---------------------------------------------------------------------------
// imhq_pkg
// Shared types and codes for the indexed min-heap queue unit.
// ---------------------------------------------------------------------------
`default_nettype none

package imhq_pkg;

  localparam int KEY_W     = 10;
  localparam int DIST_W    = 32;
  localparam int MAP_DEPTH = 1 << KEY_W;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_CHANGE  = 3'd1,
    OP_EXTRACT = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_LOOKUP  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_ABSENT  = 3'd3,
    STS_PRESENT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_REM,
    ST_RD,
    ST_CMP
  } state_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_UP,
    PH_DOWN
  } phase_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DIST_W-1:0] cost;
  } heap_entry_t;

endpackage

`default_nettype wire

// ----- design/indexed_min_heap_queue_unit.sv -----
// A miss or error finishes in the lookup state; extract/remove finish without sifting when the last slot goes.
// Throughput: one operation at a time; busy drops in the done cycle, next transfer can go there.
// Each level costs a registered heap read, then a compare/write. The receiver cannot stall done.
// Reset (rst, synchronous): a clearing pass marks every map entry absent, busy high.
// ---------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// Indexed binary min-heap with decrease/increase key, extract min and remove.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_queue_unit #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire logic [2:0]                  mode,
  input  wire logic [imhq_pkg::KEY_W-1:0]  vertex_key,
  input  wire logic [imhq_pkg::DIST_W-1:0] distance_in,
  output      logic                        done,
  output      logic [2:0]                  status,
  output      logic [imhq_pkg::KEY_W-1:0]  vertex_out,
  output      logic [imhq_pkg::DIST_W-1:0] distance_out,
  output      logic                        present,
  output      logic [10:0]                 entry_count,
  output      logic                        is_empty
);
  import imhq_pkg::*;

  // slot index and count widths
  localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int MW = SW + 1;  // map entry: {valid, slot}

  // ---- registers
  state_t            state, state_next;
  phase_t            ph_cur, ph_cur_next, ph_pend, ph_pend_next;
  logic [2:0]        op_mode;
  logic [KEY_W-1:0]  op_key;
  logic [DIST_W-1:0] op_din;
  logic [CW-1:0]     size, size_next;
  logic [SW-1:0]     hole, hole_next;
  heap_entry_t       elem, elem_next;   // the element being sifted
  logic [KEY_W-1:0]  clr_addr;
  logic [2:0]        r_status;
  logic [KEY_W-1:0]  r_vout;
  logic [DIST_W-1:0] r_dist;
  logic              r_pres;

  // ---- result staging
  logic              res_load, fin;
  logic [2:0]        res_status;
  logic [KEY_W-1:0]  res_vout;
  logic [DIST_W-1:0] res_dist;
  logic              res_pres;

  // ---- memory ports
  logic              heap_we;
  logic [SW-1:0]     heap_waddr, heap_ra, heap_rb;
  heap_entry_t       heap_wdata, heap_da, heap_db;
  logic              map_we;
  logic [KEY_W-1:0]  map_waddr, map_raddr;
  logic [MW-1:0]     map_wdata, map_rdata;

  // ---- helpers
  logic              accept, in_map, held, phase_end;
  logic [SW-1:0]     map_slot, parent;
  logic [CW-1:0]     last_cnt;
  logic [31:0]       hole32, left32, right32, size32, cnt32;
  logic              right_ok, take_right;
  heap_entry_t       child;
  logic [31:0]       child32;

  imhq_heap_mem #(.DEPTH(MAX_VERTICES), .AW(SW)) u_heap (
    .clk     (clk),
    .we      (heap_we),
    .waddr   (heap_waddr),
    .wdata   (heap_wdata),
    .raddr_a (heap_ra),
    .raddr_b (heap_rb),
    .rdata_a (heap_da),
    .rdata_b (heap_db)
  );

  imhq_map_mem #(.DW(MW)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_map   = (32'(op_key) < 32'(MAX_VERTICES));
  assign held     = in_map && map_rdata[MW-1];
  assign map_slot = map_rdata[SW-1:0];
  assign last_cnt = size - CW'(1);
  assign parent   = SW'((hole - SW'(1)) >> 1);
  assign hole32   = 32'(hole);
  assign left32   = (hole32 << 1) + 32'd1;
  assign right32  = left32 + 32'd1;
  assign size32   = 32'(size);
  assign right_ok = (right32 < size32);
  // left child only when strictly smaller than right; ties go right
  assign take_right = right_ok && !(heap_da.cost < heap_db.cost);
  assign child      = take_right ? heap_db : heap_da;
  assign child32    = take_right ? right32 : left32;
  assign cnt32      = 32'(size_next);

  always_comb begin
    state_next   = state;
    ph_cur_next  = ph_cur;
    ph_pend_next = ph_pend;
    size_next    = size;
    hole_next    = hole;
    elem_next    = elem;
    heap_we      = 1'b0;
    heap_waddr   = hole;
    heap_wdata   = elem;
    heap_ra      = '0;
    heap_rb      = '0;
    map_we       = 1'b0;
    map_waddr    = clr_addr;
    map_wdata    = '0;
    map_raddr    = vertex_key;
    res_load     = 1'b0;
    res_status   = STS_OK;
    res_vout     = op_key;
    res_dist     = '0;
    res_pres     = 1'b0;
    fin          = 1'b0;
    phase_end    = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        res_load = 1'b1;
        unique case (op_mode)
          OP_INSERT: begin
            if (!in_map || (!held && (32'(size) >= 32'(MAX_VERTICES)))) begin
              res_status = STS_FULL;
              fin        = 1'b1;
            end else if (held) begin
              heap_ra    = map_slot;
              state_next = ST_FETCH;
            end else begin
              res_dist     = op_din;
              res_pres     = 1'b1;
              elem_next    = '{key: op_key, cost: op_din};
              hole_next    = size[SW-1:0];
              size_next    = size + CW'(1);
              ph_cur_next  = PH_UP;
              ph_pend_next = PH_NONE;
              state_next   = ST_RD;
            end
          end
          OP_CHANGE: begin
            if (!held) begin
              res_status = STS_ABSENT;
              fin        = 1'b1;
            end else begin
              res_dist     = op_din;
              res_pres     = 1'b1;
              elem_next    = '{key: op_key, cost: op_din};
              hole_next    = map_slot;
              ph_cur_next  = PH_UP;
              ph_pend_next = PH_DOWN;
              state_next   = ST_RD;
            end
          end
          OP_EXTRACT: begin
            if (size == '0) begin
              res_status = STS_EMPTY;
              res_vout   = '0;
              fin        = 1'b1;
            end else begin
              heap_ra    = '0;
              heap_rb    = last_cnt[SW-1:0];
              hole_next  = '0;
              state_next = ST_REM;
            end
          end
          OP_REMOVE: begin
            if (!held) begin
              res_status = STS_ABSENT;
              fin        = 1'b1;
            end else begin
              heap_ra    = map_slot;
              heap_rb    = last_cnt[SW-1:0];
              hole_next  = map_slot;
              state_next = ST_REM;
            end
          end
          OP_LOOKUP: begin
            if (!held) begin
              res_status = STS_ABSENT;
              fin        = 1'b1;
            end else begin
              heap_ra    = map_slot;
              state_next = ST_FETCH;
            end
          end
          default: begin
            res_vout = '0;
            fin      = 1'b1;
          end
        endcase
      end
      ST_FETCH: begin
        res_load   = 1'b1;
        res_status = (op_mode == OP_INSERT) ? STS_PRESENT : STS_OK;
        res_dist   = heap_da.cost;
        res_pres   = 1'b1;
        fin        = 1'b1;
      end
      ST_REM: begin
        // heap_da: removed entry, heap_db: last entry
        res_load  = 1'b1;
        res_vout  = heap_da.key;
        res_dist  = heap_da.cost;
        map_we    = 1'b1;
        map_waddr = heap_da.key;
        map_wdata = '0;
        size_next = last_cnt;
        if (hole32 == 32'(last_cnt)) begin
          fin = 1'b1;
        end else begin
          elem_next    = heap_db;
          ph_cur_next  = PH_DOWN;
          ph_pend_next = PH_UP;
          state_next   = ST_RD;
        end
      end
      ST_RD: begin
        if (ph_cur == PH_UP) begin
          if (hole == '0) begin
            phase_end = 1'b1;
          end else begin
            heap_ra    = parent;
            state_next = ST_CMP;
          end
        end else begin
          if (left32 >= size32) begin
            phase_end = 1'b1;
          end else begin
            heap_ra    = left32[SW-1:0];
            heap_rb    = right32[SW-1:0];
            state_next = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (ph_cur == PH_UP) begin
          if (elem.cost < heap_da.cost) begin
            heap_we    = 1'b1;
            heap_wdata = heap_da;
            map_we     = 1'b1;
            map_waddr  = heap_da.key;
            map_wdata  = {1'b1, hole};
            hole_next  = parent;
            state_next = ST_RD;
          end else begin
            phase_end = 1'b1;
          end
        end else begin
          if (child.cost < elem.cost) begin
            heap_we    = 1'b1;
            heap_wdata = child;
            map_we     = 1'b1;
            map_waddr  = child.key;
            map_wdata  = {1'b1, hole};
            hole_next  = child32[SW-1:0];
            state_next = ST_RD;
          end else begin
            phase_end = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // end of a sift phase: run the pending one, or drop the element in the hole
    if (phase_end) begin
      if (ph_pend != PH_NONE) begin
        ph_cur_next  = ph_pend;
        ph_pend_next = PH_NONE;
        state_next   = ST_RD;
      end else begin
        heap_we    = 1'b1;
        heap_wdata = elem;
        map_we     = 1'b1;
        map_waddr  = elem.key;
        map_wdata  = {1'b1, hole};
        fin        = 1'b1;
      end
    end

    if (fin) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ph_cur   <= PH_NONE;
      ph_pend  <= PH_NONE;
      size     <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state   <= state_next;
      ph_cur  <= ph_cur_next;
      ph_pend <= ph_pend_next;
      size    <= size_next;
      done    <= fin;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + KEY_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= mode;
      op_key  <= vertex_key;
      op_din  <= distance_in;
    end
    hole <= hole_next;
    elem <= elem_next;
    if (res_load) begin
      r_status <= res_status;
      r_vout   <= res_vout;
      r_dist   <= res_dist;
      r_pres   <= res_pres;
    end
    if (fin) begin
      entry_count <= cnt32[10:0];
      is_empty    <= (size_next == '0);
    end
  end

  // result registers hold steady from the finishing cycle on
  always_comb begin
    status       = r_status;
    vertex_out   = r_vout;
    distance_out = r_dist;
    present      = r_pres;
  end

endmodule

`default_nettype wire

// ----- design/imhq_heap_mem.sv -----
// ---------------------------------------------------------------------------
// imhq_heap_mem
// Heap slot store: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module imhq_heap_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire imhq_pkg::heap_entry_t wdata,
  input  wire logic [AW-1:0]        raddr_a,
  input  wire logic [AW-1:0]        raddr_b,
  output      imhq_pkg::heap_entry_t rdata_a,
  output      imhq_pkg::heap_entry_t rdata_b
);
  import imhq_pkg::*;

  heap_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- design/imhq_map_mem.sv -----
// ---------------------------------------------------------------------------
// imhq_map_mem
// Key-to-slot map: valid bit plus slot per key, one write, one registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module imhq_map_mem #(
  parameter int DW = 11
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [imhq_pkg::KEY_W-1:0] waddr,
  input  wire logic [DW-1:0]              wdata,
  input  wire logic [imhq_pkg::KEY_W-1:0] raddr,
  output      logic [DW-1:0]              rdata
);
  import imhq_pkg::*;

  logic [DW-1:0] mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/imhq_checker.sv -----
// ---------------------------------------------------------------------------
// imhq_checker
// Port-level checks on the indexed min-heap queue unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_min_heap_queue_unit_assert.svh"

module imhq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic        is_empty
);
  import imhq_pkg::*;

  `IMHQ_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accept did not raise busy")
  `IMHQ_ASSERT(a_done_pulse, clk, rst, done |=> !done, "result strobe longer than one cycle")
  `IMHQ_ASSERT(a_done_after_work, clk, rst, done |-> $past(busy), "result without work")
  `IMHQ_ASSERT(a_empty_status, clk, rst, (done && (status == STS_EMPTY)) |-> is_empty,
               "empty status on non-empty heap")
  `IMHQ_ASSERT_ALWAYS(a_reset_busy, clk, rst |=> busy, "not busy after reset")

endmodule

bind indexed_min_heap_queue_unit imhq_checker u_imhq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .is_empty (is_empty)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed min-heap queue unit: drives commands,
// predicts each result with a behavioral heap model and compares all fields.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import imhq_pkg::*;

  localparam int NSLOT = 1024;
  localparam int QUIET_LIMIT = 20000;   // covers the clearing pass after reset

  // Expected outcome of one transfer.
  typedef struct {
    logic [2:0]  sts;
    logic [9:0]  vtx;
    logic [31:0] cost;
    logic        pres;
    logic [10:0] cnt;
    logic        empty;
  } heap_result_t;

  int unsigned err_count = 0;

  task automatic report(input string what);
    err_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Behavioral heap plus queue of pending results.
  class heap_scoreboard;
    logic [9:0]  slot_key  [NSLOT];
    logic [31:0] slot_dist [NSLOT];
    int unsigned key_slot  [NSLOT];
    bit          key_held  [NSLOT];
    int unsigned fill;
    heap_result_t pending[$];

    function new();
      fill = 0;
      foreach (key_held[k]) key_held[k] = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [9:0]  tk;
      logic [31:0] td;
      tk = slot_key[a]; td = slot_dist[a];
      slot_key[a] = slot_key[b]; slot_dist[a] = slot_dist[b];
      slot_key[b] = tk; slot_dist[b] = td;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
    endfunction

    function int unsigned bubble_up(int unsigned i);
      int unsigned p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (slot_dist[i] < slot_dist[p]) begin
          swap_slots(i, p);
          i = p;
        end else break;
      end
      return i;
    endfunction

    function void bubble_down(int unsigned i);
      int unsigned l, r, c;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        if (l >= fill) return;
        // ties go right
        if (r < fill) c = (slot_dist[l] < slot_dist[r]) ? l : r;
        else c = l;
        if (slot_dist[c] < slot_dist[i]) begin
          swap_slots(i, c);
          i = c;
        end else return;
      end
    endfunction

    function logic [31:0] drop_slot(int unsigned i);
      logic [9:0]  k;
      logic [31:0] d;
      int unsigned last;
      k = slot_key[i]; d = slot_dist[i];
      last = fill - 1;
      if (i != last) swap_slots(i, last);
      key_held[k] = 0;
      fill = last;
      if (i < fill) begin
        bubble_down(i);
        void'(bubble_up(i));
      end
      return d;
    endfunction

    // Note an accepted command and queue its expected result.
    function void note_command(logic [2:0] op, logic [9:0] key, logic [31:0] din);
      heap_result_t r;
      int unsigned s;
      r = '{STS_OK, 10'd0, 32'd0, 1'b0, 11'd0, 1'b0};
      case (op)
        OP_INSERT: begin
          r.vtx = key;
          if (key_held[key]) begin
            r.sts = STS_PRESENT;
            r.cost = slot_dist[key_slot[key]];
            r.pres = 1;
          end else if (fill >= NSLOT) r.sts = STS_FULL;
          else begin
            s = fill;
            slot_key[s] = key; slot_dist[s] = din;
            key_slot[key] = s; key_held[key] = 1;
            fill++;
            void'(bubble_up(s));
            r.cost = din; r.pres = 1;
          end
        end
        OP_CHANGE: begin
          r.vtx = key;
          if (!key_held[key]) r.sts = STS_ABSENT;
          else begin
            s = key_slot[key];
            slot_dist[s] = din;
            s = bubble_up(s);
            bubble_down(s);
            r.cost = din; r.pres = 1;
          end
        end
        OP_EXTRACT: begin
          if (fill == 0) r.sts = STS_EMPTY;
          else begin
            r.vtx = slot_key[0];
            r.cost = drop_slot(0);
          end
        end
        OP_REMOVE: begin
          r.vtx = key;
          if (!key_held[key]) r.sts = STS_ABSENT;
          else r.cost = drop_slot(key_slot[key]);
        end
        OP_LOOKUP: begin
          r.vtx = key;
          if (!key_held[key]) r.sts = STS_ABSENT;
          else begin
            r.cost = slot_dist[key_slot[key]];
            r.pres = 1;
          end
        end
        default: ;
      endcase
      r.cnt = fill[10:0];
      r.empty = (fill == 0);
      pending = {pending, r};
    endfunction

    // Compare one strobed result against the oldest expectation.
    task check_result(heap_result_t got);
      heap_result_t e;
      if (pending.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (got.sts !== e.sts)
        report($sformatf("status %0d, expected %0d", got.sts, e.sts));
      if (got.vtx !== e.vtx)
        report($sformatf("vertex %0d, expected %0d", got.vtx, e.vtx));
      if (got.cost !== e.cost)
        report($sformatf("distance %h, expected %h", got.cost, e.cost));
      if (got.pres !== e.pres)
        report($sformatf("present %b, expected %b", got.pres, e.pres));
      if (got.cnt !== e.cnt)
        report($sformatf("count %0d, expected %0d", got.cnt, e.cnt));
      if (got.empty !== e.empty)
        report($sformatf("empty %b, expected %b", got.empty, e.empty));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] mode = '0;
  logic [KEY_W-1:0] vertex_key = '0;
  logic [DIST_W-1:0] distance_in = '0;
  logic busy, done, present, is_empty;
  logic [2:0] status;
  logic [KEY_W-1:0] vertex_out;
  logic [DIST_W-1:0] distance_out;
  logic [10:0] entry_count;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  indexed_min_heap_queue_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .mode(mode), .vertex_key(vertex_key), .distance_in(distance_in),
    .done(done), .status(status), .vertex_out(vertex_out),
    .distance_out(distance_out), .present(present),
    .entry_count(entry_count), .is_empty(is_empty)
  );

  heap_scoreboard sb = new();
  int unsigned quiet = 0;

  // Sample transfers at the edge; the scoreboard sees inputs and outputs as
  // they stood before the edge.
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_command(mode, vertex_key, distance_in);
    if (!rst && done)
      sb.check_result('{status, vertex_out, distance_out, present, entry_count, is_empty});
    if ((start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drive one command; gap drawn first, start holds until the transfer edge.
  // With no gap, start simply stays high into the next command.
  bit no_gaps = 0;
  task automatic issue(input logic [2:0] op, input logic [9:0] key, input logic [31:0] d);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    mode <= op;
    vertex_key <= key;
    distance_in <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random key from a small pool most of the time so hits are common.
  function automatic logic [9:0] pick_key();
    if ($urandom_range(0, 9) < 8) return 10'($urandom_range(0, 47));
    return 10'($urandom());
  endfunction

  function automatic logic [31:0] pick_dist();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7);          // many ties
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty cases, extremes, ties, present insert, last-slot removal.
    issue(OP_EXTRACT, 10'd0, 32'd0);
    issue(OP_LOOKUP, 10'd5, 32'd0);
    issue(OP_CHANGE, 10'd5, 32'd1);
    issue(OP_REMOVE, 10'd5, 32'd0);
    issue(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
    issue(OP_INSERT, 10'd0, 32'd0);
    issue(OP_INSERT, 10'd7, 32'd5);
    issue(OP_INSERT, 10'd8, 32'd5);
    issue(OP_INSERT, 10'd9, 32'd5);
    issue(OP_INSERT, 10'd7, 32'd1);
    issue(OP_LOOKUP, 10'd1023, 32'd0);
    issue(OP_CHANGE, 10'd1023, 32'd2);
    issue(OP_CHANGE, 10'd0, 32'h8000_0000);
    issue(OP_REMOVE, 10'd0, 32'd0);     // removes current last entry
    issue(OP_REMOVE, 10'd7, 32'd0);
    issue(3'd5, 10'h2AA, 32'hAAAA_AAAA);
    issue(3'd7, 10'h155, 32'h5555_5555);
    issue(3'd6, 10'd0, 32'd0);
    repeat (5) issue(OP_EXTRACT, 10'd0, 32'd0);

    // Random: phases of growth, churn and drain.
    for (int i = 0; i < 640; i++) begin
      no_gaps = (i / 60) % 3 == 1;
      case ((i / 100) % 3)
        0: op = ($urandom_range(0, 9) < 6) ? OP_INSERT : 3'($urandom_range(1, 4));
        1: op = 3'($urandom_range(0, 4));
        default: op = ($urandom_range(0, 9) < 5) ? OP_EXTRACT : 3'($urandom_range(0, 4));
      endcase
      if ($urandom_range(0, 49) == 0) op = 3'($urandom_range(5, 7));
      issue(op, pick_key(), pick_dist());
    end

    // Drain part of what is left.
    no_gaps = 0;
    repeat (40) issue(OP_EXTRACT, 10'd0, 32'd0);
    start <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire

// ----- indexed_min_heap_queue_unit.f -----
+incdir+design
design/imhq_pkg.sv
design/imhq_heap_mem.sv
design/imhq_map_mem.sv
design/indexed_min_heap_queue_unit.sv
design/imhq_checker.sv
verif/testbench.sv
